// ===== rtl/core/ortb_pkg.sv =====
package ortb_pkg;

  localparam int DEPTH       = 16;
  localparam int ENTRY_WIDTH = 32;
  localparam int WORD_W      = 32;

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  typedef struct packed {
    logic                   is_replay;
    logic [ENTRY_WIDTH-1:0] entry;
    logic [WORD_W-1:0]      since;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] entry_out;
    logic [WORD_W-1:0] entry_sequence;
    logic              has_entry;
    logic              last_of_run;
    logic [WORD_W-1:0] total_written;
  } result_t;

endpackage

// ===== rtl/core/ortb_front.sv =====
module ortb_front (
  input  logic                        start,
  input  logic                        operation,
  input  logic [ortb_pkg::WORD_W-1:0] entry_in,
  input  logic [ortb_pkg::WORD_W-1:0] since_index,
  input  ortb_pkg::q_status_t         q_status,
  output logic                        busy,
  output logic                        push,
  output ortb_pkg::cmd_t              push_cmd
);
  import ortb_pkg::*;

  // Hold off new beats while the command queue has no room.
  assign busy = q_status.full;
  assign push = start & ~q_status.full;

  always_comb begin
    push_cmd.is_replay = (operation == OP_REPLAY);
    push_cmd.entry     = ENTRY_WIDTH'(entry_in);
    push_cmd.since     = push_cmd.is_replay ? since_index : '0;
  end

endmodule

// ===== rtl/core/ortb_queue.sv =====
module ortb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ortb_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output ortb_pkg::cmd_t      pop_cmd,
  output ortb_pkg::q_status_t status
);
  import ortb_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop_cmd      = slots[rd_ptr];
  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != QCNT_W'(QDEPTH))
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue pop while empty");

endmodule

// ===== rtl/core/ortb_back.sv =====
module ortb_back (
  input  logic                clk,
  input  logic                rst,
  input  ortb_pkg::q_status_t q_status,
  input  ortb_pkg::cmd_t      pop_cmd,
  output logic                pop,
  output ortb_pkg::result_t   result
);
  import ortb_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  logic [1:0]             state;
  logic [ENTRY_WIDTH-1:0] mem [DEPTH];
  logic [ENTRY_WIDTH-1:0] rd_word;

  logic [SLOT_W-1:0] oldest_slot;
  logic [CNT_W-1:0]  valid_count;
  logic [WORD_W-1:0] appended_total;

  logic [WORD_W-1:0] diff;
  logic              newer;
  logic [CNT_W-1:0]  remaining;
  logic [SLOT_W-1:0] rd_slot;
  logic [WORD_W-1:0] seq;

  logic              done;
  logic [WORD_W-1:0] res_seq;
  logic              has_entry;
  logic              last_of_run;

  logic              ring_full;
  logic [SUM_W-1:0]  append_sum;
  logic [SLOT_W-1:0] wr_slot;
  logic [CNT_W-1:0]  cap;
  logic [SUM_W-1:0]  start_sum;
  logic [SLOT_W-1:0] start_slot;
  logic              mem_we;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SUM_W-1:0] s);
    slot_wrap = (s >= SUM_W'(DEPTH)) ? SLOT_W'(s - SUM_W'(DEPTH)) : SLOT_W'(s);
  endfunction

  assign pop    = (state == S_IDLE) && !q_status.empty;
  assign mem_we = pop && !pop_cmd.is_replay;

  always_comb begin
    ring_full  = (valid_count == CNT_W'(DEPTH));
    append_sum = SUM_W'(oldest_slot) + SUM_W'(valid_count);
    wr_slot    = ring_full ? oldest_slot : slot_wrap(append_sum);
    cap        = (diff > WORD_W'(valid_count)) ? valid_count : CNT_W'(diff);
    start_sum  = SUM_W'(oldest_slot) + SUM_W'(valid_count - cap);
    start_slot = slot_wrap(start_sum);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_slot] <= pop_cmd.entry;
    end
    if (state == S_RUN) begin
      rd_word <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      oldest_slot    <= '0;
      valid_count    <= '0;
      appended_total <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop && !pop_cmd.is_replay) begin
            appended_total <= appended_total + 1'b1;
            if (ring_full) begin
              oldest_slot <= slot_inc(oldest_slot);
            end else begin
              valid_count <= valid_count + 1'b1;
            end
            done        <= 1'b1;
            res_seq     <= appended_total + 1'b1;
            has_entry   <= 1'b0;
            last_of_run <= 1'b1;
          end else if (pop) begin
            diff  <= appended_total - pop_cmd.since;
            newer <= (pop_cmd.since < appended_total);
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (!newer || cap == '0) begin
            done        <= 1'b1;
            res_seq     <= '0;
            has_entry   <= 1'b0;
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end else begin
            remaining <= cap;
            rd_slot   <= start_slot;
            seq       <= appended_total - WORD_W'(cap) + 1'b1;
            state     <= S_RUN;
          end
        end
        S_RUN: begin
          done        <= 1'b1;
          res_seq     <= seq;
          has_entry   <= 1'b1;
          last_of_run <= (remaining == CNT_W'(1));
          seq         <= seq + 1'b1;
          rd_slot     <= slot_inc(rd_slot);
          remaining   <= remaining - 1'b1;
          if (remaining == CNT_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result.done           = done;
    result.entry_out      = has_entry ? WORD_W'(rd_word) : '0;
    result.entry_sequence = res_seq;
    result.has_entry      = has_entry;
    result.last_of_run    = last_of_run;
    result.total_written  = appended_total;
  end

  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    done && !last_of_run |=> done)
    else $error("replay run broken before its last beat");

  a_oldest_until_full: assert property (@(posedge clk) disable iff (rst)
    valid_count < CNT_W'(DEPTH) |-> oldest_slot == '0)
    else $error("oldest slot moved before ring filled");

  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> remaining != '0)
    else $error("replay running with nothing left");

endmodule

// ===== rtl/core/overwrite_ring_trace_buffer.sv =====
// Order: a beat enters the command queue, then the back end pops it and registers the
//   append ack strobe; a replay passes the setup state, which answers an empty replay,
//   then returns entries one per cycle with no gaps. Throughput: one append per cycle
//   while busy is low; a replay holds the back end for its run, set by its single memory
//   read port; busy rises on a full 4-deep queue. The receiver cannot stall results.
// Reset: synchronous, clears queue, ring pointers and total; entry store is not cleared.
module overwrite_ring_trace_buffer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation,
  input  logic [ortb_pkg::WORD_W-1:0] entry_in,
  input  logic [ortb_pkg::WORD_W-1:0] since_index,
  output logic                        done,
  output logic [ortb_pkg::WORD_W-1:0] entry_out,
  output logic [ortb_pkg::WORD_W-1:0] entry_sequence,
  output logic                        has_entry,
  output logic                        last_of_run,
  output logic [ortb_pkg::WORD_W-1:0] total_written
);
  import ortb_pkg::*;

  // Front end: accept a beat and classify it as append or replay.
  logic      push;
  cmd_t      push_cmd;
  q_status_t q_status;

  // Back end handshake with the queue.
  logic      pop;
  cmd_t      pop_cmd;
  result_t   result;

  ortb_front u_front (
    .start       (start),
    .operation   (operation),
    .entry_in    (entry_in),
    .since_index (since_index),
    .q_status    (q_status),
    .busy        (busy),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Short command queue: decouple acceptance from replay runs.
  ortb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  // Back end: own the ring, the total, and drive every result beat.
  ortb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_cmd  (pop_cmd),
    .pop      (pop),
    .result   (result)
  );

  // Unpack the result beat onto the ports.
  assign done           = result.done;
  assign entry_out      = result.entry_out;
  assign entry_sequence = result.entry_sequence;
  assign has_entry      = result.has_entry;
  assign last_of_run    = result.last_of_run;
  assign total_written  = result.total_written;

endmodule
